>>> rtl/gbba_pkg.sv
// Shared constants, codes and types of the grouped bitmap block allocator.
`timescale 1ns / 1ps

package gbba_pkg;

  // Default geometry
  localparam int unsigned MAX_GROUPS_DEF       = 16;
  localparam int unsigned BLOCKS_PER_GROUP_DEF = 1024;

  // Fixed field widths
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned TOTAL_W     = 15;
  localparam int unsigned BLOCK_W     = 15;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned GCOUNT_W    = 5;
  localparam int unsigned NUMBER_W    = 32;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  // Saturation limits of the free counts
  localparam logic [CNT_W-1:0]   CNT_MAX   = 11'd2047;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 15'd32767;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INCONS   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd3;

  // Request codes
  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_COUNT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DATA  = 4'd1;

  typedef struct packed {
    logic [GCOUNT_W-1:0] group_count;
    logic                first_data_block;
  } cfg_t;

endpackage

>>> rtl/gbba_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gbba_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gbba_ctrl.sv
// Allocation and free sequencer around the bitmap and group count memories.
`timescale 1ns / 1ps

module gbba_ctrl #(
  parameter int unsigned MAX_GROUPS       = gbba_pkg::MAX_GROUPS_DEF,
  parameter int unsigned BLOCKS_PER_GROUP = gbba_pkg::BLOCKS_PER_GROUP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gbba_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [gbba_pkg::NUMBER_W-1:0]  block_number_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gbba_pkg::STATUS_W-1:0]  status_o,
  output logic [gbba_pkg::BLOCK_W-1:0]   allocated_block_o,
  output logic [gbba_pkg::TOTAL_W-1:0]   free_total_o
);

  import gbba_pkg::*;

  localparam int unsigned WPG    = (BLOCKS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned BMD    = MAX_GROUPS * WPG;
  localparam int unsigned GW     = $clog2(MAX_GROUPS + 1);
  localparam int unsigned GAW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned WAW    = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int unsigned BAW    = (BMD > 1) ? $clog2(BMD) : 1;
  localparam int unsigned OFFW   = $clog2(BLOCKS_PER_GROUP);
  localparam int unsigned TAIL   = BLOCKS_PER_GROUP % WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    (TAIL == 0) ? {WORD_BITS{1'b1}} : WORD_BITS'((64'd1 << TAIL) - 64'd1);
  localparam logic [CNT_W-1:0]     CNT_RST   = CNT_W'(BLOCKS_PER_GROUP & 2047);
  localparam logic [TOTAL_W-1:0]   TOTAL_RST = TOTAL_W'((MAX_GROUPS * BLOCKS_PER_GROUP) & 32767);
  localparam logic [NUMBER_W-1:0]  BPG_N     = NUMBER_W'(BLOCKS_PER_GROUP);
  localparam logic [BLOCK_W-1:0]   BPG_B     = BLOCK_W'(BLOCKS_PER_GROUP);
  localparam logic [BAW-1:0]       WPG_A     = BAW'(WPG);
  localparam logic [BAW-1:0]       CLR_LAST  = BAW'(BMD - 1);
  localparam logic [WAW-1:0]       W_LAST    = WAW'(WPG - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CNT,
    S_A_WRD,
    S_F_DIV,
    S_F_RMW,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [GW-1:0]        g_q, g_d;
  logic [BAW-1:0]       base_q, base_d;
  logic [BLOCK_W-1:0]   blk_q, blk_d;
  logic [WAW-1:0]       w_q, w_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NUMBER_W-1:0]  rem_q, rem_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [BAW-1:0]       clr_q, clr_d;
  logic [BAW-1:0]       waddr_q, waddr_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [BLOCK_W-1:0]   res_block_q, res_block_d;
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [BLOCK_W-1:0]   out_block_q, out_block_d;
  logic [TOTAL_W-1:0]   out_total_q, out_total_d;

  logic                 bm_we, bm_re;
  logic [BAW-1:0]       bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
  logic                 cnt_we, cnt_re;
  logic [GAW-1:0]       cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]     cnt_wdata, cnt_rdata;

  logic [GW-1:0]        ng;
  logic [GW-1:0]        g_inc;
  logic [WORD_BITS-1:0] word_eff;
  logic [BIT_W-1:0]     zero_pos;
  logic [OFFW-1:0]      off;

  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

  assign ng       = (32'(cfg_i.group_count) > MAX_GROUPS) ? GW'(MAX_GROUPS)
                                                          : GW'(cfg_i.group_count);
  assign g_inc    = g_q + GW'(1);
  assign word_eff = bm_rdata | ~((w_q == W_LAST) ? LAST_MASK : {WORD_BITS{1'b1}});
  assign zero_pos = lowest_zero(word_eff);
  assign off      = rem_q[OFFW-1:0];

  always_comb begin
    state_d      = state_q;
    g_d          = g_q;
    base_d       = base_q;
    blk_d        = blk_q;
    w_d          = w_q;
    cnt_d        = cnt_q;
    rem_d        = rem_q;
    total_d      = total_q;
    clr_d        = clr_q;
    waddr_d      = waddr_q;
    bit_d        = bit_q;
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_block_d  = out_block_q;
    out_total_d  = out_total_q;

    bm_we     = 1'b0;
    bm_waddr  = base_q + BAW'(w_q);
    bm_wdata  = bm_rdata;
    bm_re     = 1'b0;
    bm_raddr  = base_q;
    cnt_we    = 1'b0;
    cnt_waddr = GAW'(g_q);
    cnt_wdata = cnt_q;
    cnt_re    = 1'b0;
    cnt_raddr = GAW'(g_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = '0;
        if (32'(clr_q) < MAX_GROUPS) begin
          cnt_we    = 1'b1;
          cnt_waddr = GAW'(clr_q);
          cnt_wdata = CNT_RST;
        end
        clr_d = clr_q + BAW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          g_d         = '0;
          base_d      = '0;
          blk_d       = '0;
          w_d         = '0;
          res_block_d = '0;
          if (action_i == ACTION_FREE) begin
            rem_d   = block_number_i - NUMBER_W'(cfg_i.first_data_block);
            state_d = S_F_DIV;
          end else if (total_q == '0) begin
            res_status_d = STATUS_NO_SPACE;
            state_d      = S_DONE;
          end else if (ng == '0) begin
            res_status_d = STATUS_INCONS;
            state_d      = S_DONE;
          end else begin
            cnt_re    = 1'b1;
            cnt_raddr = '0;
            state_d   = S_A_CNT;
          end
        end
      end

      S_A_CNT: begin
        if (cnt_rdata != '0) begin
          cnt_d    = cnt_rdata;
          bm_re    = 1'b1;
          bm_raddr = base_q;
          state_d  = S_A_WRD;
        end else if (g_inc >= ng) begin
          res_status_d = STATUS_INCONS;
          state_d      = S_DONE;
        end else begin
          // skip an empty group and fetch the next count
          g_d       = g_inc;
          base_d    = base_q + WPG_A;
          blk_d     = blk_q + BPG_B;
          cnt_re    = 1'b1;
          cnt_raddr = GAW'(g_inc);
        end
      end

      S_A_WRD: begin
        if (&word_eff) begin
          if (w_q == W_LAST) begin
            res_status_d = STATUS_INCONS;
            state_d      = S_DONE;
          end else begin
            w_d      = w_q + WAW'(1);
            bm_re    = 1'b1;
            bm_raddr = base_q + BAW'(w_q) + BAW'(1);
          end
        end else begin
          bm_we        = 1'b1;
          bm_wdata     = bm_rdata | (WORD_BITS'(1) << zero_pos);
          cnt_we       = 1'b1;
          cnt_wdata    = cnt_q - CNT_W'(1);
          total_d      = total_q - TOTAL_W'(1);
          res_status_d = STATUS_OK;
          res_block_d  = blk_q + BLOCK_W'({w_q, 5'd0}) + BLOCK_W'(zero_pos)
                       + BLOCK_W'(cfg_i.first_data_block);
          state_d      = S_DONE;
        end
      end

      S_F_DIV: begin
        if (g_q >= ng) begin
          res_status_d = STATUS_INVALID;
          state_d      = S_DONE;
        end else if (rem_q < BPG_N) begin
          waddr_d   = base_q + BAW'(off >> BIT_W);
          bit_d     = off[BIT_W-1:0];
          bm_re     = 1'b1;
          bm_raddr  = base_q + BAW'(off >> BIT_W);
          cnt_re    = 1'b1;
          cnt_raddr = GAW'(g_q);
          state_d   = S_F_RMW;
        end else begin
          // peel off one group per cycle
          rem_d  = rem_q - BPG_N;
          g_d    = g_inc;
          base_d = base_q + WPG_A;
        end
      end

      S_F_RMW: begin
        bm_we        = 1'b1;
        bm_waddr     = waddr_q;
        bm_wdata     = bm_rdata & ~(WORD_BITS'(1) << bit_q);
        cnt_we       = 1'b1;
        cnt_wdata    = (cnt_rdata >= CNT_MAX) ? CNT_MAX : cnt_rdata + CNT_W'(1);
        total_d      = (total_q >= TOTAL_MAX) ? TOTAL_MAX : total_q + TOTAL_W'(1);
        res_status_d = STATUS_OK;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_block_d  = res_block_q;
          out_total_d  = total_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      total_q     <= TOTAL_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q          <= g_d;
    base_q       <= base_d;
    blk_q        <= blk_d;
    w_q          <= w_d;
    cnt_q        <= cnt_d;
    rem_q        <= rem_d;
    waddr_q      <= waddr_d;
    bit_q        <= bit_d;
    res_status_q <= res_status_d;
    res_block_q  <= res_block_d;
    out_status_q <= out_status_d;
    out_block_q  <= out_block_d;
    out_total_q  <= out_total_d;
  end

  gbba_ram #(
    .DEPTH  (BMD),
    .WIDTH  (WORD_BITS),
    .ADDR_W (BAW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  gbba_ram #(
    .DEPTH  (MAX_GROUPS),
    .WIDTH  (CNT_W),
    .ADDR_W (GAW)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign allocated_block_o = out_block_q;
  assign free_total_o      = out_total_q;

endmodule

>>> rtl/grouped_bitmap_block_allocator.sv
// Grouped bitmap block allocator: top level with configuration registers.
//
// Usage: a request item (action_i, block_number_i) enters on in_valid_i/in_ready_o and
// one result item (status_o, allocated_block_o, free_total_o) leaves on
// out_valid_o/out_ready_i. Configuration writes use cfg_valid_i/cfg_ready_o with a
// register index (0 group count, 1 first data block) and write data; unknown
// indexes are dropped. Write configuration only while no request is in flight.
// One item is worked on at a time. An allocate reads the group counts in order,
// skipping each empty group, then scans that group's 32-bit bitmap words in order
// past each fully used one; each count and each word is a read of its memory.
// A free locates its group by a one-group-a-cycle subtraction, then reads and
// writes back the bitmap word and the group count.
// After reset the block runs a clearing pass over all MAX_GROUPS *
// ceil(BLOCKS_PER_GROUP / 32) bitmap words (512 by default) that zeroes the bitmap
// and reloads the group counts; in_ready_o stays low until it ends. The result
// sits in an output register; a stalled receiver holds it, a new item is still
// taken, and that item's result waits in the sequencer until the register frees up.
`timescale 1ns / 1ps

module grouped_bitmap_block_allocator #(
  parameter int unsigned MAX_GROUPS       = gbba_pkg::MAX_GROUPS_DEF,
  parameter int unsigned BLOCKS_PER_GROUP = gbba_pkg::BLOCKS_PER_GROUP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbba_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [gbba_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [gbba_pkg::NUMBER_W-1:0]     block_number_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gbba_pkg::STATUS_W-1:0]     status_o,
  output logic [gbba_pkg::BLOCK_W-1:0]      allocated_block_o,
  output logic [gbba_pkg::TOTAL_W-1:0]      free_total_o
);

  import gbba_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GROUP_COUNT: cfg_d.group_count      = cfg_data_i[GCOUNT_W-1:0];
        CFG_FIRST_DATA:  cfg_d.first_data_block = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.group_count      <= GCOUNT_W'(16);
      cfg_q.first_data_block <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gbba_ctrl #(
    .MAX_GROUPS       (MAX_GROUPS),
    .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .block_number_i    (block_number_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .allocated_block_o (allocated_block_o),
    .free_total_o      (free_total_o)
  );

endmodule
